>>> rtl/b64e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, character codes and the sextet-to-ASCII mapping for the
// streaming Base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

   // Slots per queue entry: one input byte yields at most four characters
   localparam int unsigned SlotCount = 4;
   localparam int unsigned QueueDepth = 4;

   // Configuration register indexes
   localparam logic CsrUrlAlphabet = 1'b0;
   localparam logic CsrPadEnable   = 1'b1;

   // Character codes
   localparam logic [7:0] CharUpperA = 8'd65;   // 'A'
   localparam logic [7:0] LowerOfs   = 8'd71;   // 'a' - 26
   localparam logic [7:0] DigitOfs   = 8'd4;    // 52 - '0'
   localparam logic [7:0] CharPlus   = 8'd43;   // '+'
   localparam logic [7:0] CharSlash  = 8'd47;   // '/'
   localparam logic [7:0] CharMinus  = 8'd45;   // '-'
   localparam logic [7:0] CharUnder  = 8'd95;   // '_'
   localparam logic [7:0] CharPad    = 8'd61;   // '='

   // One classified item: the characters caused by one input byte
   typedef struct packed {
      logic [SlotCount-1:0][5:0] sextet;   // sextet value per slot
      logic [SlotCount-1:0]      pad;      // slot is an '=' filler
      logic [1:0]                last_idx; // index of final slot used
      logic                      last;     // final slot ends the message
   } entry_type;

   // Map one sextet onto the alphabet
   function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
      logic [7:0] w;
      w = {2'b00, v};
      if (v < 6'd26)       return w + CharUpperA;
      else if (v < 6'd52)  return w + LowerOfs;
      else if (v < 6'd62)  return w - DigitOfs;
      else if (v == 6'd62) return url ? CharMinus : CharPlus;
      else                 return url ? CharUnder : CharSlash;
   endfunction

endpackage

>>> rtl/b64e_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// Front end: takes one byte per item, regroups bits into sextets against the
// byte phase and leftover bits, and builds one queue entry per byte.
// ----------------------------------------------------------------------------
module b64e_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   input  logic                pad_enable,
   output b64e_pkg::entry_type entry
);
   import b64e_pkg::*;

   logic [1:0] byte_phase_ff, byte_phase_in;
   logic [3:0] leftover_ff, leftover_in;
   logic [1:0] phase_after;
   logic [3:0] left_after;

   // Sextets for the byte itself, then the flush and padding slots
   always_comb begin
      entry        = '0;
      phase_after  = 2'd1;
      left_after   = {2'b00, data_byte[1:0]};
      unique case (byte_phase_ff)
         2'd1: begin
            entry.sextet[0] = {leftover_ff[1:0], data_byte[7:4]};
            entry.last_idx  = 2'd0;
            phase_after     = 2'd2;
            left_after      = data_byte[3:0];
         end
         2'd2: begin
            entry.sextet[0] = {leftover_ff[3:0], data_byte[7:6]};
            entry.sextet[1] = data_byte[5:0];
            entry.last_idx  = 2'd1;
            phase_after     = 2'd0;
            left_after      = 4'd0;
         end
         default: begin
            // phase 0; phase 3 never arises and is handled the same way
            entry.sextet[0] = data_byte[7:2];
            entry.last_idx  = 2'd0;
         end
      endcase

      // Final byte: flush the partial group, then optional fillers
      entry.last = last_byte;
      if (last_byte) begin
         if (phase_after == 2'd1) begin
            entry.sextet[1] = {left_after[1:0], 4'b0000};
            entry.pad[2]    = 1'b1;
            entry.pad[3]    = 1'b1;
            entry.last_idx  = pad_enable ? 2'd3 : 2'd1;
         end else if (phase_after == 2'd2) begin
            entry.sextet[1] = {left_after[3:0], 2'b00};
            entry.pad[2]    = 1'b1;
            entry.last_idx  = pad_enable ? 2'd2 : 2'd1;
         end
      end
   end

   // Group state advances on every accepted item
   always_comb begin
      byte_phase_in = byte_phase_ff;
      leftover_in   = leftover_ff;
      if (accept) begin
         byte_phase_in = last_byte ? 2'd0 : phase_after;
         leftover_in   = last_byte ? 4'd0 : left_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_phase_ff <= 2'd0;
         leftover_ff   <= 4'd0;
      end else begin
         byte_phase_ff <= byte_phase_in;
         leftover_ff   <= leftover_in;
      end
   end

endmodule

>>> rtl/b64e_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_queue
// Small FIFO of classified entries between the front and back ends.
// ----------------------------------------------------------------------------
module b64e_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b64e_pkg::entry_type push_entry,
   input  logic                pop,
   output b64e_pkg::entry_type head_entry,
   output logic                full,
   output logic                empty
);
   import b64e_pkg::*;

   localparam int unsigned PtrBits = $clog2(QueueDepth);

   entry_type            store_ff [QueueDepth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PtrBits:0]     count_ff, count_in;

   assign full       = (count_ff == (PtrBits+1)'(QueueDepth));
   assign empty      = (count_ff == '0);
   assign head_entry = store_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/b64e_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// Back end: walks the head entry's slots, one character per cycle unless
// stalled, maps each sextet to ASCII and holds it in the output register.
// ----------------------------------------------------------------------------
module b64e_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                url_alphabet,
   input  b64e_pkg::entry_type head_entry,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_last_char
);
   import b64e_pkg::*;

   logic [1:0] slot_ff, slot_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load;
   logic       end_slot;

   assign load     = !valid_ff || !rsp_stall;
   assign end_slot = (slot_ff == head_entry.last_idx);
   assign pop      = load && !empty && end_slot;

   // Next character from the current slot
   always_comb begin
      slot_in  = slot_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = !empty;
         if (!empty) begin
            char_in = head_entry.pad[slot_ff] ? CharPad
                    : sextet_char(head_entry.sextet[slot_ff], url_alphabet);
            last_in = head_entry.last && end_slot;
            slot_in = end_slot ? 2'd0 : slot_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   // Payload register
   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = last_ff;

endmodule

>>> rtl/base64_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder: bytes in, alphabet characters out, optional '='
// padding and a mark on the final character of each message.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid req_stall req_data_byte       | in item
//          | req_last_byte                           |
//  rsp     | rsp_valid rsp_stall rsp_out_char        | out item
//          | rsp_last_char                           |
//  csr     | csr_write_enable csr_index csr_data     | reg write
//
//  A byte is taken every cycle while the 4-entry queue has room; the back
//  end sends one character per cycle while rsp_stall is low, from its
//  single-character output register.
//  A taken byte is written into the queue, then its characters pass into the
//  output register; a final byte with padding yields up to four characters.
//  Synchronous reset empties the queue and the output register.
//  rsp_stall holds the output register; req_stall rises when the queue fills.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_char,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic       csr_data
);
   import b64e_pkg::*;

   logic      url_alphabet_ff;
   logic      pad_enable_ff;
   logic      accept;
   logic      q_full;
   logic      q_empty;
   logic      q_pop;
   entry_type new_entry;
   entry_type head_entry;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         url_alphabet_ff <= 1'b1;
         pad_enable_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CsrUrlAlphabet: url_alphabet_ff <= csr_data;
            CsrPadEnable:   pad_enable_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .last_byte  (req_last_byte),
      .pad_enable (pad_enable_ff),
      .entry      (new_entry)
   );

   b64e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (new_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .full       (q_full),
      .empty      (q_empty)
   );

   b64e_back u_back (
      .clock         (clock),
      .reset         (reset),
      .url_alphabet  (url_alphabet_ff),
      .head_entry    (head_entry),
      .empty         (q_empty),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

>>> rtl/b64e_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level checks for the Base64 encoder, bound onto the top level.
// ----------------------------------------------------------------------------
module b64e_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_char,
   input logic       rsp_last_char
);

   // Output register is empty right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // Every character is from an alphabet or is the pad
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_out_char >= 8'd65 && rsp_out_char <= 8'd90) ||
                     (rsp_out_char >= 8'd97 && rsp_out_char <= 8'd122) ||
                     (rsp_out_char >= 8'd48 && rsp_out_char <= 8'd57) ||
                     rsp_out_char == 8'd43 || rsp_out_char == 8'd47 ||
                     rsp_out_char == 8'd45 || rsp_out_char == 8'd95 ||
                     rsp_out_char == 8'd61))
      else $error("character outside the alphabet");

   // Valid holds while stalled
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped under stall");

   // Payload holds while stalled
   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_char) && $stable(rsp_last_char))
      else $error("rsp payload changed under stall");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_char  (rsp_out_char),
   .rsp_last_char (rsp_last_char)
);

>>> bench/base64_stream_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder_tb
// Self-checking bench for the streaming Base64 encoder. Messages are fed one
// byte per item with random sender gaps and random receiver stalls. A
// scoreboard encodes each accepted byte on its own and compares every
// character and its end-of-message mark in order. Both alphabets and both
// padding modes are exercised, with directed corner messages first.
// ----------------------------------------------------------------------------
import b64e_pkg::*;

// One expected output character
typedef struct packed {
   logic [7:0] code;
   logic       mark;
} enc_char_type;

class b64_scoreboard;
   bit          url_alpha = 1'b1;
   bit          pad_on    = 1'b0;
   logic [1:0]  grp_pos   = 2'd0;   // byte position inside the 3-byte group
   logic [3:0]  carry     = 4'd0;   // bits not yet encoded
   enc_char_type expected[$];
   int unsigned errors, bytes_in, chars_out, messages;

   // Sextet to alphabet character
   function logic [7:0] ascii_of(logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (v <= 6'd25)      return 8'h41 + w;           // A..Z
      else if (v <= 6'd51) return 8'h61 + (w - 8'd26); // a..z
      else if (v <= 6'd61) return 8'h30 + (w - 8'd52); // 0..9
      else if (v == 6'd62) return url_alpha ? CharMinus : CharPlus;
      else                 return url_alpha ? CharUnder : CharSlash;
   endfunction

   // Accepted input byte: predict the characters it causes
   function void note_byte(logic [7:0] b, logic last);
      enc_char_type fresh[$];
      enc_char_type c;
      bytes_in++;
      c.mark = 1'b0;
      case (grp_pos)
         2'd1: begin
            c.code = ascii_of({carry[1:0], b[7:4]}); fresh.push_back(c);
            carry = b[3:0];
            grp_pos = 2'd2;
         end
         2'd2: begin
            c.code = ascii_of({carry, b[7:6]}); fresh.push_back(c);
            c.code = ascii_of(b[5:0]); fresh.push_back(c);
            carry = 4'd0;
            grp_pos = 2'd0;
         end
         default: begin
            c.code = ascii_of(b[7:2]); fresh.push_back(c);
            carry = {2'b00, b[1:0]};
            grp_pos = 2'd1;
         end
      endcase
      if (last) begin
         // flush the partial group, then pad to four characters
         if (grp_pos == 2'd1) begin
            c.code = ascii_of({carry[1:0], 4'b0000}); fresh.push_back(c);
            if (pad_on) begin
               c.code = CharPad; fresh.push_back(c); fresh.push_back(c);
            end
         end else if (grp_pos == 2'd2) begin
            c.code = ascii_of({carry, 2'b00}); fresh.push_back(c);
            if (pad_on) begin
               c.code = CharPad; fresh.push_back(c);
            end
         end
         fresh[fresh.size()-1].mark = 1'b1;
         grp_pos = 2'd0;
         carry = 4'd0;
         messages++;
      end
      foreach (fresh[i]) expected.push_back(fresh[i]);
   endfunction

   function void report_error(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
   endfunction

   // Accepted output character: compare with the oldest expectation
   function void check_char(logic [7:0] ch, logic mark);
      enc_char_type exp;
      chars_out++;
      if (expected.size() == 0) begin
         report_error($sformatf("unexpected char %h last %b", ch, mark));
         return;
      end
      exp = expected.pop_front();
      if (ch !== exp.code || mark !== exp.mark)
         report_error($sformatf("char %0d: expected char %h last %b, got char %h last %b",
                                chars_out, exp.code, exp.mark, ch, mark));
   endfunction
endclass

module base64_stream_encoder_tb;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_last_char;
   logic       csr_write_enable = 1'b0;
   logic       csr_index = 1'b0;
   logic       csr_data = 1'b0;

   bit           steady = 1'b0;   // no gaps and no stalls while set
   int unsigned  stall_cnt = 0;
   b64_scoreboard sb;

   base64_stream_encoder dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_char(rsp_out_char),
      .rsp_last_char(rsp_last_char),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   // Receiver stalls
   always @(posedge clock) begin
      if (stall_cnt != 0) begin
         stall_cnt = stall_cnt - 1;
         rsp_stall <= 1'b1;
      end else if (!steady && $urandom_range(0, 3) == 0) begin
         stall_cnt = gap_length() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Handshake monitors
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_byte(req_data_byte, req_last_byte);
      if (!reset && rsp_valid && !rsp_stall) sb.check_char(rsp_out_char, rsp_last_char);
   end

   // Offer one byte and hold it until taken; valid stays high for the next item
   task automatic send_byte(input logic [7:0] data, input logic last);
      int unsigned gap;
      gap = (steady || $urandom_range(0, 1) == 0) ? 0 : gap_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Whole message, first byte in the top used byte lane
   task automatic send_msg(input logic [31:0] bytes, input int unsigned len);
      for (int i = len - 1; i >= 0; i--) send_byte(bytes[i*8 +: 8], i == 0);
   endtask

   // Stop sending and let every expected character come out
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.expected.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_config(input logic url, input logic pad);
      drain();
      csr_write_enable <= 1'b1;
      csr_index <= CsrUrlAlphabet;
      csr_data <= url;
      @(posedge clock);
      csr_index <= CsrPadEnable;
      csr_data <= pad;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.url_alpha = url;
      sb.pad_on = pad;
   endtask

   initial begin
      int unsigned msg_left;
      logic [7:0]  b;
      logic [1:0]  cfg;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings (url alphabet, no padding)
      send_msg(32'h00FBFFBF, 3);    // sextets 62,63,62,63; group closes on last
      send_msg(32'h00000000, 1);    // one byte, two-char flush
      send_msg(32'h0000FFFF, 2);    // two bytes, three-char flush
      // standard alphabet with padding
      set_config(1'b0, 1'b1);
      send_msg(32'h00FBFFBF, 3);
      send_msg(32'h000000FF, 1);    // two '=' fillers
      send_msg(32'h000000FF, 2);    // one '=' filler
      send_msg(32'h00001083, 3);
      // url alphabet with padding
      set_config(1'b1, 1'b1);
      send_msg(32'h000000FF, 1);
      send_msg(32'h0000FFFF, 2);
      send_msg(32'h01020304, 4);    // crosses a group boundary

      // Random messages under each setting; messages may span a setting change
      msg_left = 0;
      for (int p = 0; p < 4; p++) begin
         cfg = 2'(p);
         set_config(cfg[0], cfg[1]);
         steady = (p == 2);
         for (int i = 0; i < 20; i++) begin
            if (msg_left == 0)
               msg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 14)
                                                      : $urandom_range(1, 6);
            case ($urandom_range(0, 9))
               0: b = 8'h00;
               1: b = 8'hFF;
               default: b = 8'($urandom_range(0, 255));
            endcase
            msg_left = msg_left - 1;
            if (p == 3 && i == 19) msg_left = 0;
            send_byte(b, msg_left == 0);
         end
      end
      steady = 1'b0;

      drain();
      repeat (20) @(posedge clock);
      if (sb.expected.size() != 0)
         $display("%0d expected characters never arrived", sb.expected.size());
      $display("Encoded %0d bytes in %0d messages, %0d characters compared",
               sb.bytes_in, sb.messages, sb.chars_out);
      $display("Both alphabets with and without padding, under random gaps and stalls");
      if (sb.errors == 0 && sb.expected.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
